[src/arpr_pkg.sv]
// Shared types and constants for the ARP resolver with pending queue.
package arpr_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int REQUEST_ENTRIES_DEF = 8;
  localparam int PENDING_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS         = 16;

  localparam int RBW = $clog2(MAX_RESULTS);
  localparam int RNW = $clog2(MAX_RESULTS + 1);

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] OP_REQ    = 16'd1;
  localparam logic [15:0] OP_REPLY  = 16'd2;

  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_RECV = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_RETRY    = 2'd3;

  localparam logic [31:0] LIFETIME_RST = 32'd30000;
  localparam logic [31:0] RETRY_RST    = 32'd5000;

  typedef enum logic [2:0] {
    KIND_FRAME   = 3'd0,
    KIND_REQUEST = 3'd1,
    KIND_REPLY   = 3'd2,
    KIND_DELIVER = 3'd3,
    KIND_DROP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] dst_mac;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [15:0] handle;
  } result_t;

endpackage

[src/arp_resolver_with_pending_queue.sv]
// Top level of the ARP resolver: address cache, outstanding requests and parked datagrams.
// The block takes one item at a time and walks its stores with a single scan counter.
// A send item scans the cache and then, on a miss, the outstanding requests; a received ARP frame
// scans the cache, the parked datagrams and the outstanding requests; and a tick scans
// the cache and then the outstanding requests. The results are collected in a buffer and
// then handed out one at a time, each waiting on m_tready. The scan over the stores
// walks one entry per cycle. s_tready is high only while idle.
module arp_resolver_with_pending_queue #(
  parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpr_pkg::REQUEST_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // next hop address, datagram_handle, frame_dst_mac, frame_ethertype, payload_ok,
  // arp_opcode, arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms, zero fill.
  input  logic [279:0] s_tdata,
  // action.
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_dst_mac, out_target_ip, out_target_mac, out_handle.
  output logic [143:0] m_tdata,
  // out_kind.
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int C = CACHE_ENTRIES;
  localparam int R = REQUEST_ENTRIES;
  localparam int P = PENDING_ENTRIES;
  localparam int CW = (C > 1) ? $clog2(C) : 1;
  localparam int RW = (R > 1) ? $clog2(R) : 1;
  localparam int PW = (P > 1) ? $clog2(P) : 1;
  localparam int MAXD = (C > R) ? ((C > P) ? C : P) : ((R > P) ? R : P);
  localparam int NW = $clog2(MAXD + 1);
  localparam int PNW = $clog2(P + 1);

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b0000_0000_0001,
    ST_SEND_CACHE = 12'b0000_0000_0010,
    ST_SEND_REQ   = 12'b0000_0000_0100,
    ST_SEND_PARK  = 12'b0000_0000_1000,
    ST_SEND_PEND  = 12'b0000_0001_0000,
    ST_RECV_LEARN = 12'b0000_0010_0000,
    ST_RECV_WRITE = 12'b0000_0100_0000,
    ST_RECV_FLUSH = 12'b0000_1000_0000,
    ST_RECV_REQ   = 12'b0001_0000_0000,
    ST_TICK_CACHE = 12'b0010_0000_0000,
    ST_TICK_REQ   = 12'b0100_0000_0000,
    ST_OUT        = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [31:0] lifetime;
  logic [31:0] retry;

  logic [C-1:0]  cache_valid;
  logic [31:0]   cache_ip [C];
  logic [47:0]   cache_mac [C];
  logic [31:0]   cache_ttl [C];
  logic [R-1:0]  request_valid;
  logic [31:0]   request_ip [R];
  logic [31:0]   request_ttl [R];
  logic [31:0]   pending_ip [P];
  logic [15:0]   pending_handle [P];
  logic [PNW-1:0] pcount;
  logic [PNW-1:0] wptr;

  arpr_pkg::result_t rbuf [arpr_pkg::MAX_RESULTS];
  logic [arpr_pkg::RNW-1:0] res_n;
  logic [arpr_pkg::RBW-1:0] rd;

  logic [31:0] nh;
  logic [15:0] hdl;
  logic [15:0] op;
  logic [31:0] sip;
  logic [47:0] smac;
  logic [31:0] tip;
  logic [31:0] el;

  logic [NW-1:0] cnt;
  logic          rfound;
  logic          rfree;
  logic [RW-1:0] rfree_idx;
  logic          lhit;
  logic [CW-1:0] lhit_idx;
  logic          lfree;
  logic [CW-1:0] lfree_idx;
  logic [31:0]   lmin;
  logic [CW-1:0] lmin_idx;
  logic          olast;

  logic [CW-1:0] ci;
  logic [RW-1:0] ri;
  logic [PW-1:0] pi;
  logic          last_c;
  logic          last_r;
  logic          flush_end;
  logic          c_match;
  logic          r_match;
  logic          accept;
  logic          addr_ok;
  logic [arpr_pkg::RNW-1:0] res_base;
  logic          res_full;
  logic          emit_en;
  arpr_pkg::result_t emit_res;
  logic [arpr_pkg::RNW-1:0] res_n_next;
  logic [CW-1:0] lslot;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign addr_ok   = (s_tdata[95:48] == own_mac) || (s_tdata[95:48] == arpr_pkg::BCAST_MAC);

  assign ci        = cnt[CW-1:0];
  assign ri        = cnt[RW-1:0];
  assign pi        = cnt[PW-1:0];
  assign last_c    = (cnt == NW'(C - 1));
  assign last_r    = (cnt == NW'(R - 1));
  assign flush_end = (cnt == NW'(pcount));
  assign c_match   = cache_valid[ci] && (cache_ip[ci] == ((state == ST_SEND_CACHE) ? nh : sip));
  assign r_match   = request_valid[ri] && (request_ip[ri] == ((state == ST_SEND_REQ) ? nh : sip));
  assign res_base  = (state == ST_IDLE) ? '0 : res_n;
  assign res_full  = (res_base == arpr_pkg::RNW'(arpr_pkg::MAX_RESULTS));
  assign res_n_next = (emit_en && !res_full) ? res_base + 1'b1 : res_base;
  assign lslot     = lhit ? lhit_idx : (lfree ? lfree_idx : lmin_idx);

  always_comb begin
    emit_en  = 1'b0;
    emit_res = '0;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser == arpr_pkg::ACT_RECV && addr_ok && s_tdata[112]
            && s_tdata[111:96] == arpr_pkg::ETH_IPV4) begin
          emit_en         = 1'b1;
          emit_res.kind   = arpr_pkg::KIND_DELIVER;
          emit_res.handle = s_tdata[47:32];
        end
      end
      ST_SEND_CACHE: begin
        if (c_match) begin
          emit_en          = 1'b1;
          emit_res.kind    = arpr_pkg::KIND_FRAME;
          emit_res.dst_mac = cache_mac[ci];
          emit_res.handle  = hdl;
        end
      end
      ST_SEND_PARK: begin
        if (!rfound) begin
          emit_en            = 1'b1;
          emit_res.kind      = arpr_pkg::KIND_REQUEST;
          emit_res.dst_mac   = arpr_pkg::BCAST_MAC;
          emit_res.target_ip = nh;
        end
      end
      ST_SEND_PEND: begin
        if (pcount == PNW'(P)) begin
          emit_en         = 1'b1;
          emit_res.kind   = arpr_pkg::KIND_DROP;
          emit_res.handle = hdl;
        end
      end
      ST_RECV_WRITE: begin
        if (tip == own_ip && op == arpr_pkg::OP_REQ) begin
          emit_en             = 1'b1;
          emit_res.kind       = arpr_pkg::KIND_REPLY;
          emit_res.dst_mac    = smac;
          emit_res.target_ip  = sip;
          emit_res.target_mac = smac;
        end
      end
      ST_RECV_FLUSH: begin
        if (!flush_end && pending_ip[pi] == sip && !res_full) begin
          emit_en          = 1'b1;
          emit_res.kind    = arpr_pkg::KIND_FRAME;
          emit_res.dst_mac = smac;
          emit_res.handle  = pending_handle[pi];
        end
      end
      ST_TICK_REQ: begin
        if (request_valid[ri] && request_ttl[ri] <= el && !res_full) begin
          emit_en            = 1'b1;
          emit_res.kind      = arpr_pkg::KIND_REQUEST;
          emit_res.dst_mac   = arpr_pkg::BCAST_MAC;
          emit_res.target_ip = request_ip[ri];
        end
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_en && !res_full) begin
      rbuf[res_base[arpr_pkg::RBW-1:0]] <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      own_mac       <= '0;
      own_ip        <= '0;
      lifetime      <= arpr_pkg::LIFETIME_RST;
      retry         <= arpr_pkg::RETRY_RST;
      cache_valid   <= '0;
      request_valid <= '0;
      pcount        <= '0;
      res_n         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          arpr_pkg::REG_OWN_MAC:  own_mac  <= cfg_data;
          arpr_pkg::REG_OWN_IP:   own_ip   <= cfg_data[31:0];
          arpr_pkg::REG_LIFETIME: lifetime <= cfg_data[31:0];
          arpr_pkg::REG_RETRY:    retry    <= cfg_data[31:0];
          default:                own_ip   <= own_ip;
        endcase
      end
      res_n <= res_n_next;
      case (state)
        ST_IDLE: begin
          rd <= '0;
          cnt <= '0;
          if (accept) begin
            nh   <= s_tdata[31:0];
            hdl  <= s_tdata[47:32];
            op   <= s_tdata[128:113];
            sip  <= s_tdata[160:129];
            smac <= s_tdata[208:161];
            tip  <= s_tdata[240:209];
            el   <= s_tdata[272:241];
            lhit <= 1'b0;
            lfree <= 1'b0;
            rfound <= 1'b0;
            rfree <= 1'b0;
            case (s_tuser)
              arpr_pkg::ACT_SEND: state <= ST_SEND_CACHE;
              arpr_pkg::ACT_RECV: begin
                if (addr_ok && s_tdata[112]) begin
                  if (s_tdata[111:96] == arpr_pkg::ETH_IPV4) begin
                    state <= ST_OUT;
                  end else if (s_tdata[111:96] == arpr_pkg::ETH_ARP) begin
                    state <= ST_RECV_LEARN;
                  end
                end
              end
              arpr_pkg::ACT_TICK: state <= ST_TICK_CACHE;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SEND_CACHE: begin
          if (c_match) begin
            state <= ST_OUT;
          end else if (last_c) begin
            cnt   <= '0;
            state <= ST_SEND_REQ;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SEND_REQ: begin
          if (r_match) begin
            rfound <= 1'b1;
          end
          if (!request_valid[ri] && !rfree) begin
            rfree     <= 1'b1;
            rfree_idx <= ri;
          end
          if (last_r) begin
            state <= ST_SEND_PARK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SEND_PARK: begin
          if (!rfound && rfree) begin
            request_valid[rfree_idx] <= 1'b1;
            request_ip[rfree_idx]    <= nh;
            request_ttl[rfree_idx]   <= retry;
          end
          state <= ST_SEND_PEND;
        end
        ST_SEND_PEND: begin
          if (pcount != PNW'(P)) begin
            pending_ip[pcount[PW-1:0]]     <= nh;
            pending_handle[pcount[PW-1:0]] <= hdl;
            pcount <= pcount + 1'b1;
          end
          state <= (res_n_next == '0) ? ST_IDLE : ST_OUT;
        end
        ST_RECV_LEARN: begin
          if (c_match && !lhit) begin
            lhit     <= 1'b1;
            lhit_idx <= ci;
          end
          if (!cache_valid[ci] && !lfree) begin
            lfree     <= 1'b1;
            lfree_idx <= ci;
          end
          if (cnt == '0 || cache_ttl[ci] < lmin) begin
            lmin     <= cache_ttl[ci];
            lmin_idx <= ci;
          end
          if (last_c) begin
            state <= ST_RECV_WRITE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_RECV_WRITE: begin
          cache_valid[lslot] <= 1'b1;
          cache_ip[lslot]    <= sip;
          cache_mac[lslot]   <= smac;
          cache_ttl[lslot]   <= lifetime;
          cnt  <= '0;
          wptr <= '0;
          if (tip == own_ip && op == arpr_pkg::OP_REPLY) begin
            state <= ST_RECV_FLUSH;
          end else begin
            state <= (res_n_next == '0) ? ST_IDLE : ST_OUT;
          end
        end
        ST_RECV_FLUSH: begin
          if (flush_end) begin
            pcount <= wptr;
            cnt    <= '0;
            state  <= ST_RECV_REQ;
          end else begin
            if (!(pending_ip[pi] == sip && !res_full)) begin
              pending_ip[wptr[PW-1:0]]     <= pending_ip[pi];
              pending_handle[wptr[PW-1:0]] <= pending_handle[pi];
              wptr <= wptr + 1'b1;
            end
            cnt <= cnt + 1'b1;
          end
        end
        ST_RECV_REQ: begin
          if (r_match) begin
            request_valid[ri] <= 1'b0;
            state <= (res_n_next == '0) ? ST_IDLE : ST_OUT;
          end else if (last_r) begin
            state <= (res_n_next == '0) ? ST_IDLE : ST_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_TICK_CACHE: begin
          if (cache_valid[ci]) begin
            if (cache_ttl[ci] <= el) begin
              cache_valid[ci] <= 1'b0;
            end else begin
              cache_ttl[ci] <= cache_ttl[ci] - el;
            end
          end
          if (last_c) begin
            cnt   <= '0;
            state <= ST_TICK_REQ;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_TICK_REQ: begin
          if (request_valid[ri]) begin
            if (request_ttl[ri] <= el) begin
              request_ttl[ri] <= res_full ? 32'd0 : retry;
            end else begin
              request_ttl[ri] <= request_ttl[ri] - el;
            end
          end
          if (last_r) begin
            state <= (res_n_next == '0) ? ST_IDLE : ST_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tdata  <= {rbuf[rd].handle, rbuf[rd].target_mac, rbuf[rd].target_ip,
                         rbuf[rd].dst_mac};
            m_tuser  <= rbuf[rd].kind;
            olast    <= ({1'b0, rd} == res_n - arpr_pkg::RNW'(1));
            m_tlast  <= ({1'b0, rd} == res_n - arpr_pkg::RNW'(1));
            m_tvalid <= 1'b1;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            rd       <= rd + 1'b1;
            if (olast) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == ST_OUT))
    else $error("Result shown outside the output phase.");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("Input taken while a result is pending.");

  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= PNW'(P))
    else $error("Parked datagram count exceeds the store.");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_n <= arpr_pkg::RNW'(arpr_pkg::MAX_RESULTS))
    else $error("Result count exceeds the buffer.");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ARP resolver: directed rows, then random item streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_N = 16;
  localparam int REQ_N = 8;
  localparam int PEND_N = 16;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 80;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic [31:0] nh;
    logic [15:0] hd;
    logic [47:0] fdst;
    logic [15:0] et;
    logic ok;
    logic [15:0] op;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [31:0] tip;
    logic [31:0] el;
  } in_t;

  typedef struct {
    arpr_pkg::kind_t kind;
    logic [47:0] dst;
    logic [31:0] tip;
    logic [47:0] tmac;
    logic [15:0] hd;
    logic last;
  } res_t;

  typedef struct {
    in_t it;
    int tk;
    int tn;
  } row_t;

  logic clk = 0;
  logic rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast, cfg_valid, cfg_ready;
  logic [279:0] s_tdata;
  logic [1:0] s_tuser, cfg_index;
  logic [143:0] m_tdata;
  logic [2:0] m_tuser;
  logic [47:0] cfg_data;

  arp_resolver_with_pending_queue dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [47:0] my_mac;
  logic [31:0] my_ip, lifetime, retry;
  logic c_val [CACHE_N];
  logic [31:0] c_ip [CACHE_N];
  logic [47:0] c_mac [CACHE_N];
  logic [31:0] c_ttl [CACHE_N];
  logic r_val [REQ_N];
  logic [31:0] r_ip [REQ_N];
  logic [31:0] r_ttl [REQ_N];
  logic p_val [PEND_N];
  logic [31:0] p_ip [PEND_N];
  logic [15:0] p_hd [PEND_N];

  res_t frames_due[$];
  int n_emit, errors, n_items, n_results, cycles;
  arpr_pkg::kind_t first_kind;
  bit calm, hold_on;
  event hold_off_ev;
  logic [31:0] ip_pool [8];
  logic [47:0] mac_pool [8];

  function automatic logic r1();
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] r16();
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] r32();
    return $urandom;
  endfunction

  function automatic logic [47:0] r48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic emit(arpr_pkg::kind_t k, logic [47:0] d, logic [31:0] t, logic [47:0] m,
                      logic [15:0] h);
    res_t r;
    if (n_emit >= arpr_pkg::MAX_RESULTS) return;
    r.kind = k; r.dst = d; r.tip = t; r.tmac = m; r.hd = h; r.last = 0;
    if (n_emit == 0) first_kind = k;
    frames_due.insert(frames_due.size(), r);
    n_emit++;
  endtask

  function automatic int cache_slot(logic [31:0] ip);
    for (int i = 0; i < CACHE_N; i++)
      if (c_val[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int req_slot(logic [31:0] ip);
    for (int i = 0; i < REQ_N; i++)
      if (r_val[i] && r_ip[i] == ip) return i;
    return -1;
  endfunction

  task automatic learn(logic [31:0] ip, logic [47:0] mac);
    int s;
    s = cache_slot(ip);
    for (int i = 0; i < CACHE_N && s < 0; i++)
      if (!c_val[i]) s = i;
    if (s < 0) begin
      s = 0;
      for (int i = 1; i < CACHE_N; i++)
        if (c_ttl[i] < c_ttl[s]) s = i;
    end
    c_val[s] = 1; c_ip[s] = ip; c_mac[s] = mac; c_ttl[s] = lifetime;
  endtask

  task automatic resolve_send(logic [31:0] ip, logic [15:0] h);
    int c;
    c = cache_slot(ip);
    if (c >= 0) begin
      emit(arpr_pkg::KIND_FRAME, c_mac[c], '0, '0, h);
      return;
    end
    if (req_slot(ip) < 0) begin
      emit(arpr_pkg::KIND_REQUEST, arpr_pkg::BCAST_MAC, ip, '0, '0);
      for (int i = 0; i < REQ_N; i++)
        if (!r_val[i]) begin
          r_val[i] = 1; r_ip[i] = ip; r_ttl[i] = retry;
          break;
        end
    end
    for (int i = 0; i < PEND_N; i++)
      if (!p_val[i]) begin
        p_val[i] = 1; p_ip[i] = ip; p_hd[i] = h;
        return;
      end
    emit(arpr_pkg::KIND_DROP, '0, '0, '0, h);
  endtask

  task automatic flush_parked(logic [31:0] ip, logic [47:0] mac);
    int w;
    w = 0;
    for (int i = 0; i < PEND_N; i++)
      if (p_val[i] && p_ip[i] == ip && n_emit < arpr_pkg::MAX_RESULTS) begin
        emit(arpr_pkg::KIND_FRAME, mac, '0, '0, p_hd[i]);
        p_val[i] = 0;
      end
    for (int r = 0; r < PEND_N; r++)
      if (p_val[r]) begin
        p_val[w] = 1; p_ip[w] = p_ip[r]; p_hd[w] = p_hd[r];
        w++;
      end
    for (int i = w; i < PEND_N; i++) begin
      p_val[i] = 0; p_ip[i] = 0; p_hd[i] = 0;
    end
  endtask

  task automatic resolve_item(in_t it);
    int q;
    n_emit = 0;
    if (it.action == arpr_pkg::ACT_SEND) begin
      resolve_send(it.nh, it.hd);
    end else if (it.action == arpr_pkg::ACT_RECV) begin
      if ((it.fdst == my_mac || it.fdst == arpr_pkg::BCAST_MAC) && it.ok) begin
        if (it.et == arpr_pkg::ETH_IPV4) begin
          emit(arpr_pkg::KIND_DELIVER, '0, '0, '0, it.hd);
        end else if (it.et == arpr_pkg::ETH_ARP) begin
          learn(it.sip, it.smac);
          if (it.tip == my_ip) begin
            if (it.op == arpr_pkg::OP_REPLY) begin
              flush_parked(it.sip, it.smac);
              q = req_slot(it.sip);
              if (q >= 0) begin
                r_val[q] = 0; r_ip[q] = 0; r_ttl[q] = 0;
              end
            end else if (it.op == arpr_pkg::OP_REQ) begin
              emit(arpr_pkg::KIND_REPLY, it.smac, it.sip, it.smac, '0);
            end
          end
        end
      end
    end else if (it.action == arpr_pkg::ACT_TICK) begin
      for (int i = 0; i < CACHE_N; i++)
        if (c_val[i]) begin
          if (c_ttl[i] <= it.el) begin
            c_val[i] = 0; c_ip[i] = 0; c_mac[i] = 0; c_ttl[i] = 0;
          end else c_ttl[i] -= it.el;
        end
      for (int i = 0; i < REQ_N; i++)
        if (r_val[i]) begin
          if (r_ttl[i] <= it.el) begin
            if (n_emit < arpr_pkg::MAX_RESULTS) begin
              emit(arpr_pkg::KIND_REQUEST, arpr_pkg::BCAST_MAC, r_ip[i], '0, '0);
              r_ttl[i] = retry;
            end else r_ttl[i] = 0;
          end else r_ttl[i] -= it.el;
        end
    end
    if (n_emit > 0) frames_due[frames_due.size() - 1].last = 1;
  endtask

  task automatic push_item(in_t it);
    s_tvalid <= 1;
    s_tuser <= it.action;
    s_tdata <= {7'b0, it.el, it.tip, it.smac, it.sip, it.op, it.ok, it.et, it.fdst,
                it.hd, it.nh};
    do @(posedge clk); while (!s_tready);
    resolve_item(it);
    n_items++;
    if (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      arpr_pkg::REG_OWN_MAC: my_mac = val;
      arpr_pkg::REG_OWN_IP: my_ip = val[31:0];
      arpr_pkg::REG_LIFETIME: lifetime = val[31:0];
      arpr_pkg::REG_RETRY: retry = val[31:0];
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_t mk(logic [1:0] a, logic [31:0] nh, logic [15:0] hd,
                             logic [47:0] fdst, logic [15:0] et, logic ok, logic [15:0] op,
                             logic [31:0] sip, logic [47:0] smac, logic [31:0] tip,
                             logic [31:0] el);
    in_t it;
    it.action = a; it.nh = nh; it.hd = hd; it.fdst = fdst; it.et = et; it.ok = ok;
    it.op = op; it.sip = sip; it.smac = smac; it.tip = tip; it.el = el;
    return it;
  endfunction

  function automatic in_t rand_item();
    int pick;
    logic [47:0] dst, smac;
    logic [15:0] et, op;
    logic [31:0] sip, tip, el, nh;
    pick = $urandom_range(99);
    if ($urandom_range(9) < 6) dst = my_mac;
    else if ($urandom_range(3) != 0) dst = arpr_pkg::BCAST_MAC;
    else dst = r48();
    if ($urandom_range(9) < 6) et = arpr_pkg::ETH_ARP;
    else if ($urandom_range(3) != 0) et = arpr_pkg::ETH_IPV4;
    else et = r16();
    if ($urandom_range(19) == 0) op = r16();
    else op = ($urandom_range(1) == 0) ? arpr_pkg::OP_REQ : arpr_pkg::OP_REPLY;
    sip = ($urandom_range(9) == 0) ? r32() : ip_pool[3'($urandom_range(7))];
    tip = ($urandom_range(9) < 7) ? my_ip : r32();
    el = ($urandom_range(9) == 0) ? r32() : 32'($urandom_range(0, 6000));
    smac = ($urandom_range(3) == 0) ? r48() : mac_pool[3'($urandom_range(7))];
    nh = ($urandom_range(15) == 0) ? r32() : ip_pool[3'($urandom_range(7))];
    if (pick < 40)
      return mk(arpr_pkg::ACT_SEND, nh, r16(), r48(), r16(), r1(), r16(), r32(), r48(),
                r32(), r32());
    if (pick < 85)
      return mk(arpr_pkg::ACT_RECV, r32(), r16(), dst, et, $urandom_range(9) != 0, op, sip,
                smac, tip, r32());
    if (pick < 97)
      return mk(arpr_pkg::ACT_TICK, r32(), r16(), r48(), r16(), r1(), r16(), r32(), r48(),
                r32(), el);
    return mk(ACT_UNUSED, r32(), r16(), r48(), r16(), r1(), r16(), r32(), r48(), r32(),
              r32());
  endfunction

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_on) m_tready <= 0;
    else m_tready <= calm || $urandom_range(99) >= 27;
  end

  initial forever begin
    @hold_off_ev;
    hold_on = 1;
    repeat (400) @(posedge clk);
    hold_on = 0;
  end

  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected result, kind %0d", m_tuser));
      end else begin
        e = frames_due.pop_front();
        if (m_tuser != e.kind) report($sformatf("kind %0d, want %0d", m_tuser, e.kind));
        if (m_tdata[47:0] != e.dst) report($sformatf("dst_mac %h, want %h",
                                                     m_tdata[47:0], e.dst));
        if (m_tdata[79:48] != e.tip) report($sformatf("target_ip %h, want %h",
                                                      m_tdata[79:48], e.tip));
        if (m_tdata[127:80] != e.tmac) report($sformatf("target_mac %h, want %h",
                                                        m_tdata[127:80], e.tmac));
        if (m_tdata[143:128] != e.hd) report($sformatf("handle %h, want %h",
                                                       m_tdata[143:128], e.hd));
        if (m_tlast != e.last) report($sformatf("last %b, want %b", m_tlast, e.last));
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    logic [47:0] me_mac, peer_mac;
    logic [31:0] me_ip, peer_ip;
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    cycles = 0; errors = 0; n_items = 0; n_results = 0; calm = 0; hold_on = 0;
    n_emit = 0; first_kind = arpr_pkg::KIND_FRAME;
    my_mac = 0; my_ip = 0; lifetime = arpr_pkg::LIFETIME_RST; retry = arpr_pkg::RETRY_RST;
    for (int i = 0; i < CACHE_N; i++) begin
      c_val[i] = 0; c_ip[i] = 0; c_mac[i] = 0; c_ttl[i] = 0;
    end
    for (int i = 0; i < REQ_N; i++) begin
      r_val[i] = 0; r_ip[i] = 0; r_ttl[i] = 0;
    end
    for (int i = 0; i < PEND_N; i++) begin
      p_val[i] = 0; p_ip[i] = 0; p_hd[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // With reset values in place, a request aimed at address zero is answered.
    rw.it = mk(arpr_pkg::ACT_RECV, '0, '0, arpr_pkg::BCAST_MAC, arpr_pkg::ETH_ARP, 1'b1,
               arpr_pkg::OP_REQ, 32'h0A00_0063, 48'h0200_0000_0063, '0, '0);
    rw.tk = arpr_pkg::KIND_REPLY; rw.tn = 1;
    rows.insert(rows.size(), rw);

    me_mac = 48'h0200_0000_0001; me_ip = 32'h0A00_0001;
    peer_mac = 48'h0200_0000_0002; peer_ip = 32'h0A00_0002;
    rw.it = mk(arpr_pkg::ACT_SEND, peer_ip, 16'h0011, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    rw.tk = arpr_pkg::KIND_REQUEST; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it.hd = 16'h0012; rw.tk = -1; rw.tn = 0; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_RECV, '0, 16'hFFFF, me_mac, arpr_pkg::ETH_IPV4, 1'b1, '0, '0,
               '0, '0, '0);
    rw.tk = arpr_pkg::KIND_DELIVER; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it.ok = 0; rw.tk = -1; rw.tn = 0; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_RECV, '0, 16'd1, 48'h0200_0000_0777, arpr_pkg::ETH_IPV4, 1'b1,
               '0, '0, '0, '0, '0);
    rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_RECV, '0, '0, me_mac, 16'h86DD, 1'b1, arpr_pkg::OP_REQ, peer_ip,
               peer_mac, me_ip, '0);
    rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_RECV, '0, '0, me_mac, arpr_pkg::ETH_ARP, 1'b1,
               arpr_pkg::OP_REPLY, peer_ip, peer_mac, me_ip, '0);
    rw.tk = arpr_pkg::KIND_FRAME; rw.tn = 2; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_SEND, peer_ip, 16'h0013, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    rw.tk = arpr_pkg::KIND_FRAME; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_RECV, '0, '0, arpr_pkg::BCAST_MAC, arpr_pkg::ETH_ARP, 1'b1,
               arpr_pkg::OP_REQ, 32'hFFFF_FFFF, arpr_pkg::BCAST_MAC, me_ip, '0);
    rw.tk = arpr_pkg::KIND_REPLY; rw.tn = 1; rows.insert(rows.size(), rw);
    // An odd opcode still teaches the cache, so the send that follows hits.
    rw.it = mk(arpr_pkg::ACT_RECV, '0, '0, me_mac, arpr_pkg::ETH_ARP, 1'b1, 16'hFFFF,
               32'h0A00_0003, 48'h0200_0000_0003, me_ip, '0);
    rw.tk = -1; rw.tn = 0; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_SEND, 32'h0A00_0003, 16'h0014, '0, '0, 1'b0, '0, '0, '0, '0,
               '0);
    rw.tk = arpr_pkg::KIND_FRAME; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it = mk(ACT_UNUSED, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1, '1);
    rw.tk = -1; rw.tn = 0; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_SEND, 32'h0000_0000, 16'hFFFF, '0, '0, 1'b0, '0, '0, '0, '0,
               '0);
    rw.tk = arpr_pkg::KIND_REQUEST; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_TICK, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 32'd0);
    rw.tk = -1; rw.tn = 0; rows.insert(rows.size(), rw);
    rw.it.el = arpr_pkg::RETRY_RST;
    rw.tk = arpr_pkg::KIND_REQUEST; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it.el = 32'hFFFF_FFFF;
    rw.tk = arpr_pkg::KIND_REQUEST; rw.tn = 1; rows.insert(rows.size(), rw);
    rw.it = mk(arpr_pkg::ACT_SEND, peer_ip, 16'h0015, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    rw.tk = arpr_pkg::KIND_REQUEST; rw.tn = 1; rows.insert(rows.size(), rw);

    for (int r = 0; r < rows.size(); r++) begin
      if (r == 1) begin
        drain();
        write_reg(arpr_pkg::REG_OWN_MAC, me_mac);
        write_reg(arpr_pkg::REG_OWN_IP, {16'h0, me_ip});
      end
      push_item(rows[r].it);
      if (rows[r].tn >= 0 && n_emit != rows[r].tn)
        report($sformatf("row %0d gives %0d results, want %0d", r, n_emit, rows[r].tn));
      if (rows[r].tk >= 0 && n_emit > 0 && int'(first_kind) != rows[r].tk)
        report($sformatf("row %0d first kind %0d, want %0d", r, first_kind, rows[r].tk));
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(arpr_pkg::REG_OWN_MAC, 48'h0);
          write_reg(arpr_pkg::REG_OWN_IP, 48'h0);
          write_reg(arpr_pkg::REG_LIFETIME, 48'd1);
          write_reg(arpr_pkg::REG_RETRY, 48'd1);
        end
        1: begin
          write_reg(arpr_pkg::REG_OWN_MAC, r48());
          write_reg(arpr_pkg::REG_OWN_IP, {16'h0, r32()});
          write_reg(arpr_pkg::REG_LIFETIME, 48'd4000);
          write_reg(arpr_pkg::REG_RETRY, 48'd2500);
        end
        default: begin
          write_reg(arpr_pkg::REG_OWN_MAC, arpr_pkg::BCAST_MAC);
          write_reg(arpr_pkg::REG_OWN_IP, {16'h0, 32'hFFFF_FFFF});
          write_reg(arpr_pkg::REG_LIFETIME, {16'h0, 32'hFFFF_FFFF});
          write_reg(arpr_pkg::REG_RETRY, {16'h0, 32'hFFFF_FFFF});
        end
      endcase
      for (int i = 0; i < 8; i++) begin
        ip_pool[i] = (ph == 1 && i < 4) ? 32'hC0A8_0000 + 32'(i) : r32();
        mac_pool[i] = r48();
      end
      for (int k = 0; k < 145; k++) begin
        calm = (ph == 1 && k < 50);
        if (ph == 1 && k == 70) -> hold_off_ev;
        push_item(rand_item());
      end
      calm = 0;
    end
    drain();

    $display("Ran %0d items through send, receive and tick paths; %0d results checked.",
             n_items, n_results);
    $display("Covered three register settings from the low to the high extremes.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
